FILE: rtl/rx_buffer_substring_search_unit_defines.svh
// assertion macros shared by the receive buffer search unit
`ifndef RX_BUFFER_SUBSTRING_SEARCH_UNIT_DEFINES_SVH
`define RX_BUFFER_SUBSTRING_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RBSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define RBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rbss_pkg.sv
// types and constants of the receive buffer substring search unit
package rbss_pkg;

  // store geometry
  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_DEPTH - 1);

  // transaction field widths
  localparam int OPC_W  = 2;
  localparam int BYTE_W = 8;
  localparam int PBITS_W = 64;
  localparam int PLEN_W = 4;
  localparam int LEN_W  = 10;

  // comparison window
  localparam int MAX_PATTERN = 8;
  localparam int LANES       = PBITS_W / BYTE_W;
  localparam int LANE_IDX_W  = $clog2(LANES);
  localparam int PAT_LIMIT   = (MAX_PATTERN < LANES) ? MAX_PATTERN : LANES;

  // fixed error replies, aligned so lane 0 holds the last character
  // "ERROR" CR LF
  localparam logic [LANES-1:0][BYTE_W-1:0] ERR_A_PAT  = 64'h0045_5252_4F52_0D0A;
  localparam logic [LANES-1:0]             ERR_A_MASK = 8'h7F;
  // "FAIL" CR LF
  localparam logic [LANES-1:0][BYTE_W-1:0] ERR_B_PAT  = 64'h0000_4641_494C_0D0A;
  localparam logic [LANES-1:0]             ERR_B_MASK = 8'h3F;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_ERRCHK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // sequencer controls toward the window compare unit
  typedef struct packed {
    logic load;
    logic errchk;
    logic shift;
  } win_ctl_t;

endpackage

FILE: rtl/rbss_if.sv
// handshake channels of the receive buffer search unit
interface rbss_in_if;
  logic                          valid;
  logic                          ready;
  logic [rbss_pkg::OPC_W-1:0]    opcode;
  logic [rbss_pkg::BYTE_W-1:0]   data_byte;
  logic [rbss_pkg::PBITS_W-1:0]  pattern_bytes;
  logic [rbss_pkg::PLEN_W-1:0]   pattern_length;

  modport source (output valid, opcode, data_byte, pattern_bytes, pattern_length,
                  input ready);
  modport sink   (input valid, opcode, data_byte, pattern_bytes, pattern_length,
                  output ready);
endinterface

interface rbss_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [rbss_pkg::LEN_W-1:0]   stored_length;

  modport source (output valid, found, stored_length, input ready);
  modport sink   (input valid, found, stored_length, output ready);
endinterface

FILE: rtl/rbss_ram.sv
// generic single write port ram with registered read
module rbss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rbss_window.sv
// sliding byte window with masked pattern compare
module rbss_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rbss_pkg::win_ctl_t                  ctl,
  input  logic [rbss_pkg::BYTE_W-1:0]         shift_data,
  input  logic [rbss_pkg::PBITS_W-1:0]        pat_bytes,
  input  logic [rbss_pkg::PLEN_W-1:0]         pat_len,
  output logic                                match
);

  localparam int LANES = rbss_pkg::LANES;

  logic [LANES-1:0][rbss_pkg::BYTE_W-1:0] win_r;
  logic [LANES-1:0]                       vld_r;
  logic [LANES-1:0][rbss_pkg::BYTE_W-1:0] apat_a_r, apat_a_nxt;
  logic [LANES-1:0]                       mask_a_r, mask_a_nxt;
  logic                                   en_b_r;
  logic [LANES-1:0][rbss_pkg::BYTE_W-1:0] pat_arr;
  logic [rbss_pkg::PLEN_W-1:0]            len_sat;
  logic [LANES-1:0]                       ok_a, ok_b;

  assign pat_arr = pat_bytes;
  assign len_sat = (pat_len > rbss_pkg::PLEN_W'(rbss_pkg::PAT_LIMIT)) ?
                   rbss_pkg::PLEN_W'(rbss_pkg::PAT_LIMIT) : pat_len;

  // align the pattern so its last byte sits in lane 0, or take the fixed error reply on a check
  always_comb begin
    logic [rbss_pkg::LANE_IDX_W-1:0] sel;
    sel = '0;
    apat_a_nxt = '0;
    mask_a_nxt = '0;
    if (ctl.errchk) begin
      apat_a_nxt = rbss_pkg::ERR_A_PAT;
      mask_a_nxt = rbss_pkg::ERR_A_MASK;
    end else begin
      for (int i = 0; i < LANES; i++) begin
        if (rbss_pkg::PLEN_W'(i) < len_sat) begin
          sel = rbss_pkg::LANE_IDX_W'(len_sat - rbss_pkg::PLEN_W'(i) - 1'b1);
          apat_a_nxt[i] = pat_arr[sel];
          mask_a_nxt[i] = 1'b1;
        end
      end
    end
  end

  // window fill state and second-pattern enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      en_b_r <= 1'b0;
    end else if (ctl.load) begin
      vld_r  <= '0;
      en_b_r <= ctl.errchk;
    end else if (ctl.shift) begin
      vld_r  <= {vld_r[LANES-2:0], 1'b1};
    end
  end

  // window bytes and loaded pattern
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      apat_a_r <= apat_a_nxt;
      mask_a_r <= mask_a_nxt;
    end
    if (ctl.shift) begin
      win_r <= {win_r[LANES-2:0], shift_data};
    end
  end

  // per-lane compare, unmasked lanes always agree
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ok_a[i] = !mask_a_r[i] || (vld_r[i] && (win_r[i] == apat_a_r[i]));
      ok_b[i] = !rbss_pkg::ERR_B_MASK[i] ||
                (vld_r[i] && (win_r[i] == rbss_pkg::ERR_B_PAT[i]));
    end
  end

  assign match = (&ok_a) || (en_b_r && (&ok_b));

endmodule

FILE: rtl/rx_buffer_substring_search_unit.sv
// receive byte store with substring search, top level
//
// in_ch carries one command per transaction: append a byte, clear the
// store, search for a pattern of up to eight bytes, or check for the
// error replies "ERROR" CR LF and "FAIL" CR LF. out_ch returns one
// transaction per command: found and the stored byte count afterwards.
// The store holds up to 1023 bytes; appends beyond that are dropped.
// Append and clear finish in the accept cycle; the result is valid on
// the next cycle. A search or error check streams the stored bytes one
// per cycle out of the store ram through a window compare unit; each
// byte passes the ram read register and the window registers before
// the match is folded into the result register.
// in_ch.ready is high only while the sequencer is idle and the output
// register is empty or being drained. A stalled out_ch holds its
// transaction and blocks the next command. Reset empties the store
// (count zero) and drops any pending result; no clearing pass is run.
`include "rx_buffer_substring_search_unit_defines.svh"

module rx_buffer_substring_search_unit (
  input  logic              clk,
  input  logic              rst_n,
  rbss_in_if.sink           in_ch,
  rbss_out_if.source        out_ch
);

  rbss_pkg::state_t                st_r, st_nxt;
  logic [rbss_pkg::ADDR_W-1:0]     fill_r, fill_nxt;
  logic [rbss_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic                            hit_r, hit_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic                            found_r, found_nxt;
  logic [rbss_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic                            in_acc, rd_en, scan_done, wr_en, out_load;
  logic                            match;
  logic [rbss_pkg::BYTE_W-1:0]     rd_data;
  rbss_pkg::op_t                   op;
  rbss_pkg::win_ctl_t              win_ctl;

  assign op       = rbss_pkg::op_t'(in_ch.opcode);
  assign in_ch.ready = (st_r == rbss_pkg::ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign rd_en    = (st_r == rbss_pkg::ST_SCAN) && (addr_r != fill_r);
  assign scan_done = (st_r == rbss_pkg::ST_SCAN) && !rd_en && !rd_vld_r;
  assign wr_en    = in_acc && (op == rbss_pkg::OP_APPEND) && (fill_r != rbss_pkg::FILL_MAX);
  assign out_load = (in_acc && ((op == rbss_pkg::OP_APPEND) || (op == rbss_pkg::OP_CLEAR)))
                    || scan_done;

  assign win_ctl.load   = in_acc && ((op == rbss_pkg::OP_SEARCH) ||
                                     (op == rbss_pkg::OP_ERRCHK));
  assign win_ctl.errchk = (op == rbss_pkg::OP_ERRCHK);
  assign win_ctl.shift  = rd_vld_r;

  // byte store
  rbss_ram #(
    .WIDTH(rbss_pkg::BYTE_W),
    .DEPTH(rbss_pkg::BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill_r),
    .wdata (in_ch.data_byte),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  // window compare unit
  rbss_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (win_ctl),
    .shift_data (rd_data),
    .pat_bytes  (in_ch.pattern_bytes),
    .pat_len    (in_ch.pattern_length),
    .match      (match)
  );

  // sequencer and result next state
  always_comb begin
    st_nxt      = st_r;
    fill_nxt    = fill_r;
    addr_nxt    = addr_r;
    rd_vld_nxt  = rd_vld_r;
    hit_nxt     = hit_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    found_nxt   = found_r;
    len_nxt     = len_r;
    unique case (st_r)
      rbss_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (op) inside
            rbss_pkg::OP_APPEND: begin
              if (fill_r != rbss_pkg::FILL_MAX) begin
                fill_nxt = fill_r + 1'b1;
              end
              found_nxt = 1'b0;
            end
            rbss_pkg::OP_CLEAR: begin
              fill_nxt  = '0;
              found_nxt = 1'b0;
            end
            rbss_pkg::OP_SEARCH, rbss_pkg::OP_ERRCHK: begin
              st_nxt     = rbss_pkg::ST_SCAN;
              addr_nxt   = '0;
              rd_vld_nxt = 1'b0;
              hit_nxt    = 1'b0;
            end
            default: begin
              st_nxt = rbss_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rbss_pkg::ST_SCAN: begin
        if (rd_en) begin
          addr_nxt = addr_r + 1'b1;
        end
        rd_vld_nxt = rd_en;
        hit_nxt    = hit_r || match;
        if (scan_done) begin
          found_nxt = hit_r || match;
          st_nxt    = rbss_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = rbss_pkg::ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_vld_nxt = 1'b1;
      len_nxt     = rbss_pkg::LEN_W'(fill_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= rbss_pkg::ST_IDLE;
      fill_r    <= '0;
      addr_r    <= '0;
      rd_vld_r  <= 1'b0;
      hit_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      fill_r    <= fill_nxt;
      addr_r    <= addr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      hit_r     <= hit_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    len_r   <= len_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.found         = found_r;
  assign out_ch.stored_length = len_r;

  // checks
  `RBSS_ASSERT_NOW(a_scan_addr_in_range, st_r == rbss_pkg::ST_SCAN, addr_r <= fill_r,
    "scan address ran past the fill count")
  `RBSS_ASSERT_NOW(a_fill_stable_in_scan, st_r == rbss_pkg::ST_SCAN, $stable(fill_r),
    "fill count changed during a scan")
  `RBSS_ASSERT_NOW(a_no_result_overrun, out_load && out_vld_r, out_ch.ready,
    "result loaded over an undelivered transaction")
  `RBSS_ASSERT_NEXT(a_query_starts_scan, win_ctl.load, st_r == rbss_pkg::ST_SCAN && !out_vld_r,
    "query did not start a scan with an empty result register")

endmodule

FILE: sim/rx_buffer_substring_search_unit_tb.sv
// testbench for the receive buffer substring search unit: directed and random command traffic
`timescale 1ns / 100ps

module rx_buffer_substring_search_unit_tb;
  import rbss_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int STORE_MAX      = BUFFER_DEPTH - 1;

  // fixed replies, first character in the lowest byte
  localparam logic [63:0] ERROR_REPLY = 64'h000A_0D52_4F52_5245;
  localparam logic [63:0] FAIL_REPLY  = 64'h0000_0A0D_4C49_4146;
  // byte values that build up replies and near misses
  localparam logic [79:0] ALPHABET    = 80'h45_52_4F_46_41_49_4C_0D_0A_00;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] stored_length;
  } result_t;

  logic clk;
  logic rst_n;

  rbss_in_if  in_ch ();
  rbss_out_if out_ch ();

  rx_buffer_substring_search_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the store contents and fill count
  logic [BYTE_W-1:0] mirror_bytes [BUFFER_DEPTH];
  int                mirror_fill;

  result_t pending_results [$];
  result_t oldest_result;
  int      error_count;
  int      items_sent;
  int      quiet_cycles;
  bit      idle_on;
  int      hold_request;
  int      holds_served;
  int      hold_left;
  int      stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // substring lookup in the mirrored store
  function automatic bit pattern_in_mirror(input logic [63:0] pat, input int len);
    bit hit;
    bit same;
    if (len == 0) return 1'b1;
    if (len > mirror_fill) return 1'b0;
    hit = 1'b0;
    for (int s = 0; s + len <= mirror_fill && !hit; s++) begin
      same = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (mirror_bytes[s + k] != pat[8*k +: 8]) same = 1'b0;
      end
      hit = same;
    end
    return hit;
  endfunction

  // update the mirror with one command and work out its result
  function automatic result_t apply_command(input op_t cmd_op, input logic [7:0] cmd_data,
                                            input logic [63:0] cmd_pattern,
                                            input logic [3:0] cmd_len);
    result_t r;
    int      n;
    r.found = 1'b0;
    case (cmd_op)
      OP_APPEND: begin
        if (mirror_fill < STORE_MAX) begin
          mirror_bytes[mirror_fill] = cmd_data;
          mirror_fill++;
        end
      end
      OP_CLEAR: begin
        mirror_fill = 0;
        foreach (mirror_bytes[i]) mirror_bytes[i] = '0;
      end
      OP_SEARCH: begin
        n = (cmd_len > PAT_LIMIT) ? PAT_LIMIT : int'(cmd_len);
        r.found = pattern_in_mirror(cmd_pattern, n);
      end
      default: begin
        r.found = pattern_in_mirror(ERROR_REPLY, 7) || pattern_in_mirror(FAIL_REPLY, 6);
      end
    endcase
    r.stored_length = LEN_W'(mirror_fill);
    return r;
  endfunction

  // stored bytes from start as a pattern, lanes past len random
  function automatic logic [63:0] mirror_slice(input int start, input int len);
    logic [63:0] p;
    p = {$urandom, $urandom};
    for (int k = 0; k < len; k++) p[8*k +: 8] = mirror_bytes[start + k];
    return p;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return ALPHABET[8*$urandom_range(0, 9) +: 8];
  endfunction

  // drop valid for one cycle with noise on the payload
  task automatic release_input();
    @(negedge clk);
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= 2'($urandom_range(0, 3));
    in_ch.data_byte      <= 8'($urandom_range(0, 255));
    in_ch.pattern_bytes  <= {$urandom, $urandom};
    in_ch.pattern_length <= 4'($urandom_range(0, 15));
  endtask

  // offer one command and record its result once accepted
  task automatic send_command(input op_t cmd_op, input logic [7:0] cmd_data,
                              input logic [63:0] cmd_pattern, input logic [3:0] cmd_len);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) release_input();
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= cmd_op;
    in_ch.data_byte      <= cmd_data;
    in_ch.pattern_bytes  <= cmd_pattern;
    in_ch.pattern_length <= cmd_len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_command(cmd_op, cmd_data, cmd_pattern, cmd_len));
    items_sent++;
  endtask

  task automatic append_byte(input logic [7:0] d);
    send_command(OP_APPEND, d, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
  endtask

  task automatic clear_store();
    send_command(OP_CLEAR, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                 4'($urandom_range(0, 15)));
  endtask

  task automatic search_pattern(input logic [63:0] p, input logic [3:0] len);
    send_command(OP_SEARCH, 8'($urandom_range(0, 255)), p, len);
  endtask

  task automatic check_errors();
    send_command(OP_ERRCHK, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                 4'($urandom_range(0, 15)));
  endtask

  task automatic append_text(input logic [63:0] text, input int len);
    for (int i = 0; i < len; i++) append_byte(text[8*i +: 8]);
  endtask

  // sender stays quiet until every result is back
  task automatic wait_for_results();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // searches and error check on an empty store
  task automatic test_empty_store();
    search_pattern({$urandom, $urandom}, 4'd0);
    search_pattern(64'h0, 4'd1);
    search_pattern('1, 4'd15);
    check_errors();
  endtask

  // extreme bytes, zero bytes in a pattern, saturated and oversized lengths
  task automatic test_pattern_edges();
    logic [63:0] p;
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'h00);
    search_pattern({56'hFF_FFFF_FFFF_FFFF, 8'h00}, 4'd1);
    search_pattern(mirror_slice(1, 2), 4'd2);
    search_pattern(mirror_slice(0, 3), 4'd4);
    append_text(64'h0102_0304_05AA_55FF, 5);
    search_pattern(mirror_slice(0, 8), 4'd15);
    search_pattern(mirror_slice(0, 8), 4'd8);
    p = mirror_slice(0, 8);
    p[63:56] = ~p[63:56];
    search_pattern(p, 4'd8);
    search_pattern(p, 4'd7);
    clear_store();
  endtask

  // both replies, a truncated reply and its completion
  task automatic test_error_replies();
    append_text(FAIL_REPLY, 6);
    check_errors();
    clear_store();
    append_text(ERROR_REPLY, 6);
    check_errors();
    append_byte(8'h0A);
    check_errors();
    clear_store();
  endtask

  // fill the store to its limit, search across it, then overflow it
  task automatic test_store_full();
    logic [63:0] p;
    idle_on = 1'b0;
    clear_store();
    while (mirror_fill < STORE_MAX - 7) append_byte(8'($urandom_range(0, 255)));
    append_text(ERROR_REPLY, 7);
    check_errors();
    search_pattern(mirror_slice(0, 8), 4'd8);
    search_pattern(mirror_slice(STORE_MAX - 8, 8), 4'd15);
    append_byte(8'h5A);
    append_byte(8'hA5);
    p = mirror_slice(STORE_MAX - 6, 6);
    p[55:48] = 8'h5A;
    search_pattern(p, 4'd7);
    clear_store();
    check_errors();
    idle_on = 1'b1;
  endtask

  // long receiver hold while commands keep coming, then a full pause
  task automatic test_backpressure();
    hold_request++;
    for (int i = 0; i < 16; i++) append_byte(random_char());
    search_pattern(mirror_slice(mirror_fill - 4, 4), 4'd4);
    wait_for_results();
    check_errors();
    clear_store();
  endtask

  // mostly well-formed traffic: replies, substrings of the store, near misses
  task automatic test_random_traffic(input int num_items);
    int          target;
    int          pick;
    int          start;
    int          len;
    logic [63:0] p;
    target = items_sent + num_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4 || (mirror_fill > 200 && pick < 12)) begin
        clear_store();
      end else if (pick < 44) begin
        append_byte(random_char());
      end else if (pick < 50) begin
        p   = ($urandom_range(0, 1) == 0) ? ERROR_REPLY : FAIL_REPLY;
        len = (p == ERROR_REPLY) ? 7 : 6;
        if ($urandom_range(0, 2) == 0) p[8*$urandom_range(0, len - 1) +: 8] = random_char();
        append_text(p, len);
      end else if (pick < 74 && mirror_fill > 0) begin
        start = $urandom_range(0, mirror_fill - 1);
        len   = $urandom_range(1, (mirror_fill - start < 8) ? mirror_fill - start : 8);
        p     = mirror_slice(start, len);
        if ($urandom_range(0, 3) == 0) p[8*$urandom_range(0, len - 1) +: 8] = random_char();
        if (len == 8 && $urandom_range(0, 1) == 0) search_pattern(p, 4'($urandom_range(8, 15)));
        else search_pattern(p, 4'(len));
      end else if (pick < 86) begin
        search_pattern({$urandom, $urandom}, 4'($urandom_range(0, 15)));
      end else if (pick < 95) begin
        check_errors();
      end else if (pick < 97) begin
        wait_for_results();
      end else begin
        p = {$urandom, $urandom};
        p[7:0] = random_char();
        search_pattern(p, 4'($urandom_range(0, 1)));
      end
    end
  endtask

  // receiver side: random stall bursts and requested long holds
  initial begin
    out_ch.ready = 1'b0;
    holds_served = 0;
    hold_left    = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_request) begin
        holds_served = hold_request;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0d stored_length %0d",
               out_ch.found, out_ch.stored_length);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_ch.found !== oldest_result.found) begin
          $error("found: expected %0d, actual %0d", oldest_result.found, out_ch.found);
          error_count++;
        end
        if (out_ch.stored_length !== oldest_result.stored_length) begin
          $error("stored_length: expected %0d, actual %0d",
                 oldest_result.stored_length, out_ch.stored_length);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end while (quiet_cycles < WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // test sequence
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_APPEND;
    in_ch.data_byte      = '0;
    in_ch.pattern_bytes  = '0;
    in_ch.pattern_length = '0;
    error_count          = 0;
    items_sent           = 0;
    hold_request         = 0;
    idle_on              = 1'b1;
    mirror_fill          = 0;
    foreach (mirror_bytes[i]) mirror_bytes[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_pattern_edges();
    test_error_replies();
    test_store_full();
    test_backpressure();
    test_random_traffic(480);
    // last stretch without idling on either side
    wait_for_results();
    idle_on = 1'b0;
    test_random_traffic(60);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rbss_pkg.sv
rtl/rbss_if.sv
rtl/rbss_ram.sv
rtl/rbss_window.sv
rtl/rx_buffer_substring_search_unit.sv
sim/rx_buffer_substring_search_unit_tb.sv
